### rtl/core/cfrc_pkg.sv
// shared types, codes and the crc-8 byte update for the command frame receiver
package cfrc_pkg;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_GOOD     = 2'd1;
  localparam logic [1:0] KIND_BAD_CRC  = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  // configuration register indexes
  localparam logic CFG_START_CODE = 1'b0;
  localparam logic CFG_MAX_BYTES  = 1'b1;

  // reset values of the configuration registers
  localparam logic [7:0] START_CODE_RST = 8'hAA;
  localparam logic [8:0] MAX_BYTES_RST  = 9'd128;

  // crc-8, poly x^8+x^2+x+1, msb first
  localparam logic [7:0] CRC_POLY = 8'h07;

  // check byte position is the payload length plus this offset
  localparam logic [8:0] CHECK_OFFSET = 9'd3;

  // one result word from the frame parser
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] command_code;
    logic [7:0] payload_count;
  } cfrc_res_t;

  // crc update over one byte, eight shift steps on an 8-bit value
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/command_frame_receiver_crc8.sv
// top level of the command frame receiver with crc-8 check
//
// Takes one received serial byte per input word (in_valid / in_ready) and
// gives zero or one result word per byte (out_valid / out_ready): a payload
// byte as it arrives, a good or crc-mismatch verdict on the check byte, or
// an overflow drop when the frame reaches the byte limit unfinished.
// Bytes before a start code are discarded without any result.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 start
// code, 1 frame byte limit); write only while the block is idle.
// Timing: a byte accepted into the input register is decoded there by
// combinational logic; its result is written to the output register when
// the byte steps on, which a stalled output word can hold back.
// Throughput: one byte per cycle while no result waits on a stalled output;
// the crc-8 byte update and position decode lie between the two registers.
// Stall: when out_ready is low the output word holds; a byte that gives no
// result still moves through, a byte that gives one waits in the input
// register and in_ready drops until the output word is taken.
// Reset: both registers empty, hunting for a start code, start code 0xAA,
// byte limit 128.
module command_frame_receiver_crc8 import cfrc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_command_code,
  output logic [7:0] out_payload_count,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata
);

  logic [7:0] start_code_r;
  logic [8:0] max_bytes_r;
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  cfrc_res_t  res;
  cfrc_res_t  out_r;
  logic       step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= START_CODE_RST;
      max_bytes_r  <= MAX_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_CODE: start_code_r <= cfg_wdata[7:0];
        CFG_MAX_BYTES:  max_bytes_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the input word moves on unless its result has nowhere to go
  assign step     = in_vld_r && (!res.valid || !out_r.valid || out_ready);
  assign in_ready = !in_vld_r || step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  cfrc_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_code (start_code_r),
    .max_bytes  (max_bytes_r),
    .step       (step),
    .rx_byte    (in_byte_r),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (!out_r.valid || out_ready) begin
      out_r.valid <= step && res.valid;
    end
    if ((!out_r.valid || out_ready) && step && res.valid) begin
      out_r.kind          <= res.kind;
      out_r.data_byte     <= res.data_byte;
      out_r.command_code  <= res.command_code;
      out_r.payload_count <= res.payload_count;
    end
  end

  assign out_valid         = out_r.valid;
  assign out_kind          = out_r.kind;
  assign out_data_byte     = out_r.data_byte;
  assign out_command_code  = out_r.command_code;
  assign out_payload_count = out_r.payload_count;

endmodule

### rtl/core/cfrc_parse.sv
// frame state tracker: position, running crc, held command and length
module cfrc_parse import cfrc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] start_code,
  input  logic [8:0] max_bytes,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output cfrc_res_t  res
);

  logic [8:0] pos_r, pos_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;

  logic [8:0] pos_inc;
  logic [8:0] check_pos;
  logic [7:0] crc_upd;
  logic       advance_pos;
  logic       have_payload;

  assign pos_inc   = pos_r + 9'd1;
  assign check_pos = {1'b0, len_r} + CHECK_OFFSET;
  assign crc_upd   = crc8_update(crc_r, rx_byte);

  // decode the byte against the current frame position
  always_comb begin
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    advance_pos  = 1'b0;
    have_payload = 1'b0;
    res          = '0;
    priority if (pos_r == 9'd0) begin
      if (rx_byte == start_code) begin
        cmd_nxt     = '0;
        len_nxt     = '0;
        crc_nxt     = crc8_update(8'h00, rx_byte);
        advance_pos = 1'b1;
      end
    end else if (pos_r == 9'd1) begin
      cmd_nxt     = rx_byte;
      crc_nxt     = crc_upd;
      advance_pos = 1'b1;
    end else if (pos_r == 9'd2) begin
      len_nxt     = rx_byte;
      crc_nxt     = crc_upd;
      advance_pos = 1'b1;
    end else if (pos_r == check_pos) begin
      // check byte closes the frame
      res.valid = 1'b1;
      res.kind  = (rx_byte == crc_r) ? KIND_GOOD : KIND_BAD_CRC;
      pos_nxt   = '0;
      crc_nxt   = '0;
    end else begin
      crc_nxt      = crc_upd;
      have_payload = 1'b1;
      advance_pos  = 1'b1;
    end

    // byte limit check after the position moves
    if (advance_pos) begin
      if (pos_inc >= max_bytes) begin
        res.valid = 1'b1;
        res.kind  = KIND_OVERFLOW;
        pos_nxt   = '0;
        crc_nxt   = '0;
      end else begin
        pos_nxt = pos_inc;
        if (have_payload) begin
          res.valid = 1'b1;
          res.kind  = KIND_PAYLOAD;
        end
      end
    end

    res.data_byte     = rx_byte;
    res.command_code  = cmd_nxt;
    res.payload_count = len_nxt;
  end

  // state update when a word is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= '0;
      cmd_r <= '0;
      len_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      cmd_r <= cmd_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

### rtl/core/cfrc_checker.sv
// port-level checks for the command frame receiver, bound to the top level
module cfrc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_data_byte,
  input logic [7:0] out_command_code,
  input logic [7:0] out_payload_count
);

  // result channel is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word present after reset");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_data_byte) && $stable(out_command_code) && $stable(out_payload_count))
    else $error("stalled output word changed");

  // input back-pressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without a stalled output word");

  // with the output register empty, the input side is never blocked
  a_ready_recover: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low while output register empty");

endmodule

bind command_frame_receiver_crc8 cfrc_checker u_cfrc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_kind          (out_kind),
  .out_data_byte     (out_data_byte),
  .out_command_code  (out_command_code),
  .out_payload_count (out_payload_count)
);
